// ===== rtl/kdc_pkg.sv =====
package kdc_pkg;

  // func codes of a request
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_KEY   = 2'd2;

  // command codes, bits 7..5 of a command-port write
  localparam logic [2:0] CMD_MODE_SET   = 3'd0;
  localparam logic [2:0] CMD_READ_FIFO  = 3'd2;
  localparam logic [2:0] CMD_READ_DISP  = 3'd3;
  localparam logic [2:0] CMD_WRITE_DISP = 3'd4;
  localparam logic [2:0] CMD_CLEAR      = 3'd6;

  // clear fill select, bits 3..2 of a clear command
  localparam logic [1:0] FILL_SEL_BLANK = 2'b10;
  localparam logic [1:0] FILL_SEL_ONES  = 2'b11;

  localparam logic [7:0] FILL_ZERO  = 8'h00;
  localparam logic [7:0] FILL_BLANK = 8'h20;
  localparam logic [7:0] FILL_ONES  = 8'hFF;

  typedef struct packed {
    logic       wr;         // data-port write
    logic       rd_adv;     // data-port read of the display
    logic       load_addr;  // read/write display command
    logic [3:0] addr_raw;
    logic       auto_inc;
    logic       fill;
    logic [7:0] fill_val;
    logic [7:0] wdata;
  } disp_ctl_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] key;
  } fifo_ctl_t;

endpackage

// ===== rtl/kdc_req_if.sv =====
interface kdc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic       a0;
  logic [7:0] data;

  modport source (output valid, output func, output a0, output data, input ready);
  modport sink (input valid, input func, input a0, input data, output ready);
endinterface

// ===== rtl/kdc_rsp_if.sv =====
interface kdc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink (input valid, input read_data, output ready);
endinterface

// ===== rtl/kdc_display.sv =====
module kdc_display
  import kdc_pkg::*;
#(
  parameter int DISPLAY_DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  disp_ctl_t ctl,
  output logic [7:0] rd_data
);

  localparam int AW = $clog2(DISPLAY_DEPTH);

  logic [7:0]    ram [DISPLAY_DEPTH];
  logic [AW-1:0] addr;
  logic          auto_inc;

  logic [4:0]    raw_ext;
  logic [4:0]    raw_mod;
  logic [AW-1:0] addr_inc;

  // command address bits taken mod depth; raw < 16 <= 2 * depth
  assign raw_ext = {1'b0, ctl.addr_raw};
  assign raw_mod = (raw_ext >= 5'(DISPLAY_DEPTH)) ? raw_ext - 5'(DISPLAY_DEPTH) : raw_ext;
  assign addr_inc = (addr == AW'(DISPLAY_DEPTH - 1)) ? '0 : addr + 1'b1;

  assign rd_data = ram[addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      addr     <= '0;
      auto_inc <= 1'b0;
      for (int i = 0; i < DISPLAY_DEPTH; i++) begin
        ram[i] <= FILL_ZERO;
      end
    end else begin
      if (ctl.fill) begin
        for (int i = 0; i < DISPLAY_DEPTH; i++) begin
          ram[i] <= ctl.fill_val;
        end
      end
      if (ctl.wr) begin
        ram[addr] <= ctl.wdata;
      end
      if (ctl.load_addr) begin
        addr     <= raw_mod[AW-1:0];
        auto_inc <= ctl.auto_inc;
      end else if ((ctl.wr || ctl.rd_adv) && auto_inc) begin
        addr <= addr_inc;
      end
    end
  end

endmodule

// ===== rtl/kdc_keyfifo.sv =====
module kdc_keyfifo
  import kdc_pkg::*;
#(
  parameter int FIFO_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  fifo_ctl_t  ctl,
  output logic [7:0] rd_data,
  output logic [7:0] status
);

  localparam int PW = $clog2(FIFO_DEPTH);

  logic [7:0]    mem [FIFO_DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic          overflow;
  logic          underflow;

  logic [PW-1:0] head_inc;
  logic [PW-1:0] tail_inc;
  logic [PW-1:0] count;
  logic          empty;
  logic          full;

  assign head_inc = (head == PW'(FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == PW'(FIFO_DEPTH - 1)) ? '0 : tail + 1'b1;
  assign count    = (tail >= head) ? tail - head : tail + PW'(FIFO_DEPTH) - head;
  assign empty    = (head == tail);
  // ring keeps one slot free
  assign full     = (count == PW'(FIFO_DEPTH - 1));

  assign rd_data = empty ? 8'h00 : mem[head];
  assign status  = {full, 1'b0, overflow, underflow, 4'(count)};

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      overflow  <= 1'b0;
      underflow <= 1'b0;
    end else if (ctl.clear) begin
      head      <= '0;
      tail      <= '0;
      overflow  <= 1'b0;
      underflow <= 1'b0;
    end else if (ctl.push) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        tail <= tail_inc;
      end
    end else if (ctl.pop) begin
      if (empty) begin
        underflow <= 1'b1;
      end else begin
        head <= head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !full) begin
      mem[tail] <= ctl.key;
    end
  end

endmodule

// ===== rtl/keypad_display_controller_core.sv =====
// Keyboard and display controller.
// req carries one bus access or key arrival per transfer: func selects bus
// write, bus read or key code from the scanner, a0 picks data or
// command/status port, data is the write byte or the key code.
// rsp returns exactly one byte per request: the read result for a bus read,
// zero for everything else.
// A request taken into the request register executes there; its response is
// registered in the response register, which drives rsp.
// Throughput: one request per cycle while rsp does not stall; all state
// updates are register operations, including the whole-display fill of a clear.
// A stall on rsp holds the response register; req stays ready while the
// request register is empty or can move into the response register, so one
// more request is taken while the previous response waits, then req stalls.
// Reset (rst, synchronous) zeroes the display, empties the key FIFO, clears
// the flags, the display address and auto-increment, and selects FIFO reads.
// Mode set commands are accepted; display mode has no effect on any output.
module keypad_display_controller_core
  import kdc_pkg::*;
#(
  parameter int DISPLAY_DEPTH = 8,
  parameter int FIFO_DEPTH    = 8
) (
  input logic      clk,
  input logic      rst,
  kdc_req_if.sink  req,
  kdc_rsp_if.source rsp
);

  logic       s1_valid;
  logic [1:0] s1_func;
  logic       s1_a0;
  logic [7:0] s1_data;

  logic       out_valid;
  logic [7:0] out_data;

  logic       read_from_display;
  logic       rfd_next;

  logic       adv;
  logic       exec;
  logic [7:0] result;

  disp_ctl_t  disp_ctl;
  fifo_ctl_t  fifo_ctl;
  logic [7:0] disp_rd;
  logic [7:0] fifo_rd;
  logic [7:0] fifo_status;

  assign adv       = !out_valid || rsp.ready;
  assign exec      = s1_valid && adv;
  assign req.ready = !s1_valid || adv;
  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;

  always_comb begin
    disp_ctl          = '0;
    fifo_ctl          = '0;
    disp_ctl.wdata    = s1_data;
    disp_ctl.addr_raw = s1_data[3:0];
    disp_ctl.auto_inc = s1_data[4];
    fifo_ctl.key      = s1_data;
    rfd_next          = read_from_display;
    result            = 8'h00;
    case (s1_func)
      FUNC_WRITE: begin
        if (!s1_a0) begin
          disp_ctl.wr = exec;
        end else begin
          case (s1_data[7:5])
            CMD_READ_FIFO: rfd_next = 1'b0;
            CMD_READ_DISP: begin
              rfd_next           = 1'b1;
              disp_ctl.load_addr = exec;
            end
            CMD_WRITE_DISP: disp_ctl.load_addr = exec;
            CMD_CLEAR: begin
              if (s1_data[0]) begin
                fifo_ctl.clear    = exec;
                disp_ctl.fill     = exec;
                disp_ctl.fill_val = FILL_ZERO;
              end else begin
                fifo_ctl.clear = exec && s1_data[1];
                disp_ctl.fill  = exec && s1_data[4];
                case (s1_data[3:2])
                  FILL_SEL_BLANK: disp_ctl.fill_val = FILL_BLANK;
                  FILL_SEL_ONES:  disp_ctl.fill_val = FILL_ONES;
                  default:        disp_ctl.fill_val = FILL_ZERO;
                endcase
              end
            end
            default: ;
          endcase
        end
      end
      FUNC_READ: begin
        if (s1_a0) begin
          result = fifo_status;
        end else if (read_from_display) begin
          result          = disp_rd;
          disp_ctl.rd_adv = exec;
        end else begin
          result       = fifo_rd;
          fifo_ctl.pop = exec;
        end
      end
      FUNC_KEY: fifo_ctl.push = exec;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid          <= 1'b0;
      out_valid         <= 1'b0;
      read_from_display <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= s1_valid;
      end
      if (exec) begin
        read_from_display <= rfd_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_func <= req.func;
      s1_a0   <= req.a0;
      s1_data <= req.data;
    end
    if (exec) begin
      out_data <= result;
    end
  end

  kdc_display #(
    .DISPLAY_DEPTH(DISPLAY_DEPTH)
  ) u_display (
    .clk     (clk),
    .rst     (rst),
    .ctl     (disp_ctl),
    .rd_data (disp_rd)
  );

  kdc_keyfifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_keyfifo (
    .clk     (clk),
    .rst     (rst),
    .ctl     (fifo_ctl),
    .rd_data (fifo_rd),
    .status  (fifo_status)
  );

endmodule
